// File: rtl/core/arpeggiator_note_stepper_assert.svh
// Assertion macros shared by the arpeggiator note stepper checker.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef ARPEGGIATOR_NOTE_STEPPER_ASSERT_SVH
`define ARPEGGIATOR_NOTE_STEPPER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ARP_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ARP_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/core/arp_pkg.sv
// Shared types and codes for the arpeggiator note stepper.
// No dependencies; used by the top level and its checker.
`default_nettype none

package arp_pkg;

	// Command codes of an input transaction.
	localparam logic [2:0] CMD_TICK   = 3'd0;
	localparam logic [2:0] CMD_TOGGLE = 3'd1;
	localparam logic [2:0] CMD_PLAY   = 3'd2;
	localparam logic [2:0] CMD_STOP   = 3'd3;
	localparam logic [2:0] CMD_RESET  = 3'd4;

	// Play modes.
	localparam logic [2:0] MODE_UP     = 3'd0;
	localparam logic [2:0] MODE_DOWN   = 3'd1;
	localparam logic [2:0] MODE_UPDOWN = 3'd2;
	localparam logic [2:0] MODE_ORDER  = 3'd3;
	localparam logic [2:0] MODE_RANDOM = 3'd4;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_PLAY_MODE   = 2'd0;
	localparam logic [1:0] REG_LOOP_ENABLE = 2'd1;
	localparam logic [1:0] REG_STEP_FRAMES = 2'd2;
	localparam logic [1:0] REG_GATE_FRAMES = 2'd3;

	// Reset values.
	localparam logic [15:0] STEP_FRAMES_RST = 16'd12000;
	localparam logic [15:0] GATE_FRAMES_RST = 16'd9600;
	localparam logic [31:0] RANDOM_SEED     = 32'h005a17b3;

	typedef struct packed {
		logic [2:0] command;
		logic [6:0] note_number;
	} in_t;

	typedef struct packed {
		logic       note_start;
		logic [6:0] note_value;
		logic       gate_open;
		logic       playing;
		logic       accepted;
	} out_t;

endpackage

`default_nettype wire

// File: rtl/core/arpeggiator_note_stepper.sv
// Arpeggiator note stepper: sequencer, note memories and configuration registers.
// Depends on arp_pkg.
//
// Usage: one input transaction (command, note_number) on in_valid/in_ready gives
// exactly one result transaction on out_valid/out_ready. Registers are to be
// written through the APB-style port while the block is idle; the block itself
// does not enforce this. pready is always high. The block works on one
// transaction at a time and drops in_ready meanwhile. In random mode the note
// index comes from a one-bit-per-cycle remainder over the 32-bit random word.
// After a toggle that adds or removes a note the play order is rebuilt, in up,
// down and up-down modes by ranking each note against all others through one
// shared compare unit; the note memories have registered reads. After a
// play-mode change the next transaction first pays one such rebuild.
// Reset clears the note count, run state and counters, and loads the register
// defaults. The result sits in an output register, so a new transaction is
// taken while it waits; a stalled receiver holds back the next result, and no
// further transaction is taken until that result is placed.
`default_nettype none

module arpeggiator_note_stepper #(
	parameter int MAX_NOTES = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire arp_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output arp_pkg::out_t      out_data,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [3:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import arp_pkg::*;

	localparam int IW  = $clog2(MAX_NOTES);
	localparam int CW  = $clog2(MAX_NOTES + 1);
	localparam int PW  = $clog2(2 * MAX_NOTES);
	localparam int PW1 = PW + 1;
	localparam int RW  = IW + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_SRCH  = 4'd2;
	localparam logic [3:0] S_SHR   = 4'd3;
	localparam logic [3:0] S_SHW   = 4'd4;
	localparam logic [3:0] S_RLOAD = 4'd5;
	localparam logic [3:0] S_RGET  = 4'd6;
	localparam logic [3:0] S_RANK  = 4'd7;
	localparam logic [3:0] S_RWR   = 4'd8;
	localparam logic [3:0] S_RFIN  = 4'd9;
	localparam logic [3:0] S_PICK  = 4'd10;
	localparam logic [3:0] S_DIV   = 4'd11;
	localparam logic [3:0] S_PADDR = 4'd12;
	localparam logic [3:0] S_PFIN  = 4'd13;
	localparam logic [3:0] S_DONE  = 4'd14;

	// Configuration registers.
	logic [2:0]  mode_q;
	logic        loop_q;
	logic [15:0] step_q;
	logic [15:0] gate_q;

	// Sequencer and run state.
	logic [3:0]    state_q;
	logic [2:0]    cmd_q;
	logic [6:0]    note_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] cursor_q;
	logic [15:0]   elapsed_q;
	logic          run_q;
	logic          fresh_q;
	logic          svalid_q;
	logic [6:0]    snote_q;
	logic [31:0]   rnd_q;
	logic          dirty_q;
	logic          map_q;
	logic          desc_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic          cmpv_q;
	logic          found_q;
	logic [IW-1:0] fidx_q;
	logic [IW-1:0] rank_q;
	logic [IW-1:0] cur_q;
	logic          curv_q;
	logic [6:0]    ei_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] rem_q;
	logic [4:0]    bit_q;
	logic          res_start_q;
	logic          res_gate_q;
	logic          res_acc_q;
	logic          out_valid_q;
	out_t          out_q;

	// Note memories.
	logic [6:0]    entry_mem [MAX_NOTES];
	logic [6:0]    order_mem [MAX_NOTES];
	logic [6:0]    ent_rd_q;
	logic [6:0]    ord_rd_q;
	logic          ent_we;
	logic [IW-1:0] ent_wa;
	logic [IW-1:0] ent_ra;
	logic [6:0]    ent_wd;
	logic          ord_we;
	logic [IW-1:0] ord_wa;
	logic [IW-1:0] ord_ra;
	logic [6:0]    ord_wd;

	// Shared arithmetic.
	logic [15:0]   step_eff;
	logic [15:0]   glen;
	logic          gate_now;
	logic [15:0]   elapsed_inc;
	logic [PW1-1:0] cnt_e;
	logic [PW1-1:0] cur_e;
	logic [PW1-1:0] tcm2;
	logic [PW-1:0]  clen;
	logic [PW-1:0]  cur_p1;
	logic [PW1-1:0] idx_a;
	logic [PW1-1:0] idx_b;
	logic [31:0]   xs1;
	logic [31:0]   xs2;
	logic [31:0]   xs3;
	logic [RW-1:0] rem2;
	logic [RW-1:0] rem_nx;
	logic          srch_issue;
	logic          srch_end;
	logic          rank_issue;
	logic          rank_less;
	logic [CW-1:0] fidx_p1;
	logic          cfg_wr;
	logic [2:0]    cfg_mode;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign pready    = 1'b1;

	// Step length, clamped gate length and saturating frame count.
	always_comb begin
		step_eff    = (step_q == 16'd0) ? 16'd1 : step_q;
		glen        = (gate_q < step_eff) ? gate_q : step_eff;
		gate_now    = (elapsed_q < glen);
		elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	end

	// Cycle length and play index derived from the cursor.
	always_comb begin
		cnt_e  = PW1'(cnt_q);
		cur_e  = PW1'(cursor_q);
		tcm2   = (cnt_e << 1) - PW1'(2);
		clen   = (mode_q == MODE_UPDOWN && cnt_q > CW'(1)) ? tcm2[PW-1:0] : PW'(cnt_q);
		cur_p1 = cursor_q + PW'(1);
		idx_a  = cur_e;
		if (mode_q == MODE_UPDOWN && cur_e >= cnt_e) begin
			idx_a = (cur_e <= tcm2) ? tcm2 - cur_e : '0;
		end
		idx_b = (idx_a >= cnt_e) ? '0 : idx_a;
	end

	// Random word update and one remainder step.
	always_comb begin
		xs1    = rnd_q ^ (rnd_q << 13);
		xs2    = xs1 ^ (xs1 >> 17);
		xs3    = xs2 ^ (xs2 << 5);
		rem2   = {rem_q, rnd_q[bit_q]};
		rem_nx = (rem2 >= RW'(cnt_q)) ? rem2 - RW'(cnt_q) : rem2;
	end

	// Search and rank control, and configuration write decode.
	always_comb begin
		srch_issue = (i_q != cnt_q);
		srch_end   = !srch_issue && !cmpv_q;
		rank_issue = (j_q != cnt_q);
		rank_less  = (mode_q == MODE_DOWN) ? (ent_rd_q > ei_q) : (ent_rd_q < ei_q);
		fidx_p1    = CW'(fidx_q) + CW'(1);
		cfg_wr     = psel && penable && pwrite;
		cfg_mode   = (pwdata[2:0] > MODE_RANDOM) ? MODE_UP : pwdata[2:0];
	end

	// Memory port control.
	always_comb begin
		ent_we = 1'b0;
		ent_wa = cnt_q[IW-1:0];
		ent_wd = note_q;
		ent_ra = i_q[IW-1:0];
		ord_we = 1'b0;
		ord_wa = rank_q;
		ord_wd = ei_q;
		ord_ra = idx_q;
		unique case (state_q)
			S_SRCH: begin
				if (srch_end && !found_q && cnt_q != CW'(MAX_NOTES)) begin
					ent_we = 1'b1;
				end
			end
			S_SHR: begin
				ent_ra = IW'(i_q + CW'(1));
			end
			S_SHW: begin
				ent_we = 1'b1;
				ent_wa = i_q[IW-1:0];
				ent_wd = ent_rd_q;
			end
			S_RANK: begin
				ent_ra = j_q[IW-1:0];
			end
			S_RWR: begin
				ord_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Note memories with registered reads.
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[ent_wa] <= ent_wd;
		end
		if (ord_we) begin
			order_mem[ord_wa] <= ord_wd;
		end
		ent_rd_q <= entry_mem[ent_ra];
		ord_rd_q <= order_mem[ord_ra];
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[3:2])
			REG_PLAY_MODE:   prdata = {29'd0, mode_q};
			REG_LOOP_ENABLE: prdata = {31'd0, loop_q};
			REG_STEP_FRAMES: prdata = {16'd0, step_q};
			REG_GATE_FRAMES: prdata = {16'd0, gate_q};
		endcase
	end

	// Sequencer, run state and configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_UP;
			loop_q      <= 1'b1;
			step_q      <= STEP_FRAMES_RST;
			gate_q      <= GATE_FRAMES_RST;
			state_q     <= S_IDLE;
			cmd_q       <= CMD_TICK;
			note_q      <= '0;
			cnt_q       <= '0;
			cursor_q    <= '0;
			elapsed_q   <= '0;
			run_q       <= 1'b0;
			fresh_q     <= 1'b0;
			svalid_q    <= 1'b0;
			snote_q     <= '0;
			rnd_q       <= RANDOM_SEED;
			dirty_q     <= 1'b0;
			map_q       <= 1'b0;
			desc_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			cmpv_q      <= 1'b0;
			found_q     <= 1'b0;
			fidx_q      <= '0;
			rank_q      <= '0;
			cur_q       <= '0;
			curv_q      <= 1'b0;
			ei_q        <= '0;
			idx_q       <= '0;
			rem_q       <= '0;
			bit_q       <= '0;
			res_start_q <= 1'b0;
			res_gate_q  <= 1'b0;
			res_acc_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q       <= in_data.command;
						note_q      <= in_data.note_number;
						res_start_q <= 1'b0;
						res_gate_q  <= 1'b0;
						res_acc_q   <= 1'b1;
						if (dirty_q) begin
							// A pending mode change first rebuilds the play order.
							dirty_q <= 1'b0;
							map_q   <= 1'b0;
							i_q     <= '0;
							state_q <= S_RLOAD;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					unique case (cmd_q)
						CMD_TICK: begin
							if (run_q) begin
								if (fresh_q) begin
									fresh_q <= 1'b0;
									state_q <= S_PICK;
								end else if (elapsed_q >= step_eff) begin
									if (cur_p1 >= clen) begin
										if (loop_q) begin
											cursor_q  <= '0;
											elapsed_q <= '0;
											state_q   <= S_PICK;
										end else begin
											run_q     <= 1'b0;
											svalid_q  <= 1'b0;
											elapsed_q <= '0;
											fresh_q   <= 1'b0;
										end
									end else begin
										cursor_q  <= cur_p1;
										elapsed_q <= '0;
										state_q   <= S_PICK;
									end
								end else begin
									res_gate_q <= gate_now;
									elapsed_q  <= elapsed_inc;
								end
							end
						end
						CMD_TOGGLE: begin
							i_q     <= '0;
							cmpv_q  <= 1'b0;
							found_q <= 1'b0;
							state_q <= S_SRCH;
						end
						CMD_PLAY: begin
							if (cnt_q == '0) begin
								res_acc_q <= 1'b0;
							end else begin
								run_q     <= 1'b1;
								cursor_q  <= '0;
								elapsed_q <= '0;
								fresh_q   <= 1'b1;
								svalid_q  <= 1'b0;
							end
						end
						CMD_STOP: begin
							run_q     <= 1'b0;
							svalid_q  <= 1'b0;
							elapsed_q <= '0;
							fresh_q   <= 1'b0;
						end
						CMD_RESET: begin
							cursor_q  <= '0;
							elapsed_q <= '0;
							if (run_q) begin
								fresh_q <= 1'b1;
							end
						end
						default: begin
							res_acc_q <= 1'b0;
						end
					endcase
				end
				S_SRCH: begin
					// Pipelined scan of the entry table for the toggled note.
					if (srch_issue) begin
						i_q <= i_q + CW'(1);
					end
					cmpv_q <= srch_issue;
					if (cmpv_q && ent_rd_q == note_q) begin
						found_q <= 1'b1;
						fidx_q  <= IW'(i_q - CW'(1));
					end
					if (srch_end) begin
						desc_q <= (mode_q == MODE_UPDOWN) && (cur_e >= cnt_e);
						map_q  <= 1'b1;
						curv_q <= 1'b0;
						if (found_q) begin
							if (fidx_p1 < cnt_q) begin
								i_q     <= CW'(fidx_q);
								state_q <= S_SHR;
							end else begin
								cnt_q   <= cnt_q - CW'(1);
								i_q     <= '0;
								state_q <= S_RLOAD;
							end
						end else if (cnt_q == CW'(MAX_NOTES)) begin
							res_acc_q <= 1'b0;
							state_q   <= S_DONE;
						end else begin
							cnt_q   <= cnt_q + CW'(1);
							i_q     <= '0;
							state_q <= S_RLOAD;
						end
					end
				end
				S_SHR: begin
					state_q <= S_SHW;
				end
				S_SHW: begin
					// Close the gap left by the removed note.
					if (i_q + CW'(2) < cnt_q) begin
						i_q     <= i_q + CW'(1);
						state_q <= S_SHR;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						i_q     <= '0;
						state_q <= S_RLOAD;
					end
				end
				S_RLOAD: begin
					state_q <= (i_q == cnt_q) ? S_RFIN : S_RGET;
				end
				S_RGET: begin
					ei_q   <= ent_rd_q;
					j_q    <= '0;
					cmpv_q <= 1'b0;
					if (mode_q == MODE_ORDER || mode_q == MODE_RANDOM) begin
						rank_q  <= i_q[IW-1:0];
						state_q <= S_RWR;
					end else begin
						rank_q  <= '0;
						state_q <= S_RANK;
					end
				end
				S_RANK: begin
					// Count the notes that sort ahead of this one.
					if (rank_issue) begin
						j_q <= j_q + CW'(1);
					end
					cmpv_q <= rank_issue;
					if (cmpv_q && rank_less) begin
						rank_q <= rank_q + IW'(1);
					end
					if (!rank_issue && !cmpv_q) begin
						state_q <= S_RWR;
					end
				end
				S_RWR: begin
					if (map_q && svalid_q && ei_q == snote_q) begin
						cur_q  <= rank_q;
						curv_q <= 1'b1;
					end
					i_q     <= i_q + CW'(1);
					state_q <= S_RLOAD;
				end
				S_RFIN: begin
					if (!map_q) begin
						state_q <= S_EXEC;
					end else begin
						state_q <= S_DONE;
						// Stop if empty; else follow the sounding note or restart.
						if (cnt_q == '0) begin
							run_q     <= 1'b0;
							svalid_q  <= 1'b0;
							elapsed_q <= '0;
							fresh_q   <= 1'b0;
						end else if (run_q && !curv_q) begin
							cursor_q  <= '0;
							elapsed_q <= '0;
							fresh_q   <= 1'b1;
						end else if (curv_q && mode_q != MODE_RANDOM) begin
							if (desc_q && cur_q != '0 && PW1'(cur_q) < cnt_e - PW1'(1)) begin
								cursor_q <= PW'(tcm2 - PW1'(cur_q));
							end else begin
								cursor_q <= PW'(cur_q);
							end
						end else if (cursor_q >= clen) begin
							cursor_q <= '0;
						end
					end
				end
				S_PICK: begin
					if (mode_q == MODE_RANDOM) begin
						rnd_q   <= xs3;
						rem_q   <= '0;
						bit_q   <= 5'd31;
						state_q <= S_DIV;
					end else begin
						idx_q   <= idx_b[IW-1:0];
						state_q <= S_PADDR;
					end
				end
				S_DIV: begin
					// Restoring remainder, one bit of the random word per cycle.
					rem_q <= rem_nx[IW-1:0];
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd0) begin
						idx_q   <= rem_nx[IW-1:0];
						state_q <= S_PADDR;
					end
				end
				S_PADDR: begin
					state_q <= S_PFIN;
				end
				S_PFIN: begin
					snote_q     <= ord_rd_q;
					svalid_q    <= 1'b1;
					res_start_q <= 1'b1;
					res_gate_q  <= gate_now;
					elapsed_q   <= elapsed_inc;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q      <= 1'b1;
						out_q.note_start <= res_start_q;
						out_q.note_value <= svalid_q ? snote_q : 7'd0;
						out_q.gate_open  <= res_gate_q;
						out_q.playing    <= run_q;
						out_q.accepted   <= res_acc_q;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Register writes are to arrive only while the sequencer is idle; this block does not enforce it.
			if (cfg_wr) begin
				unique case (paddr[3:2])
					REG_PLAY_MODE: begin
						if (cfg_mode != mode_q) begin
							mode_q  <= cfg_mode;
							dirty_q <= 1'b1;
							if (cnt_q == '0) begin
								run_q     <= 1'b0;
								svalid_q  <= 1'b0;
								elapsed_q <= '0;
								fresh_q   <= 1'b0;
							end else begin
								cursor_q  <= '0;
								elapsed_q <= '0;
								if (run_q) begin
									fresh_q <= 1'b1;
								end
							end
						end
					end
					REG_LOOP_ENABLE: loop_q <= pwdata[0];
					REG_STEP_FRAMES: step_q <= pwdata[15:0];
					REG_GATE_FRAMES: gate_q <= pwdata[15:0];
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/arp_checker.sv
// Port-level checker for the arpeggiator note stepper, bound to the top level.
// Depends on arp_pkg and arpeggiator_note_stepper_assert.svh.
`default_nettype none

`include "arpeggiator_note_stepper_assert.svh"

module arp_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          out_valid,
	input wire logic          out_ready,
	input wire arp_pkg::out_t out_data
);
	import arp_pkg::*;

	// A stalled result transaction holds its payload.
	`ARP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// A note is only triggered while the sequence runs.
	`ARP_ASSERT_NOW(a_start_playing, out_valid && out_data.note_start, out_data.playing, "note start while stopped")

	// The gate only opens while the sequence runs.
	`ARP_ASSERT_NOW(a_gate_playing, out_valid && out_data.gate_open, out_data.playing, "gate open while stopped")

	// A stopped sequence reports no sounding note.
	`ARP_ASSERT_NOW(a_idle_silent, out_valid && !out_data.playing, out_data.note_value == 7'd0, "note value while stopped")

endmodule

bind arpeggiator_note_stepper arp_checker u_arp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire
